>>> rtl/suffix_automaton_builder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for suffix_automaton_builder
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SUFFIX_AUTOMATON_BUILDER_DEFINES_SVH
`define SUFFIX_AUTOMATON_BUILDER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sab assertion failed");

// next-cycle implication, disabled in reset
`define SAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sab assertion failed");

`endif

>>> rtl/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg
// Shared field width and command/status codes of the suffix automaton builder.
// ----------------------------------------------------------------------------
package sab_pkg;

	localparam int FW = 11;

	typedef enum logic [1:0] {
		CMD_APPEND  = 2'd0,
		CMD_READ    = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NOREAD = 2'd2
	} status_t;

endpackage

>>> rtl/suffix_automaton_builder.sv
// ----------------------------------------------------------------------------
// suffix_automaton_builder
// Online suffix automaton construction over a node table in single-port RAM.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; s_tready is low while it is worked on
// and while its result waits on the master side. A read looks up a node and
// one of its transitions, a rejected append or no-op is answered from idle,
// a restart clears the root's transitions (the same pass runs once after reset before the first transaction).
// An append clears a new node and walks the suffix links, and copies the
// transitions of a node when it is cloned; the single-port transition RAM is
// swept one entry per cycle to clear a node, and read then written per entry to copy one.
// ----------------------------------------------------------------------------
`include "suffix_automaton_builder_defines.svh"

module suffix_automaton_builder #(
	parameter int MAX_NODES     = 2048,
	parameter int ALPHABET_SIZE = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // symbol[4:0], node_index[15:5]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // last_node, node_count, target_node, link_node,
	                              // longest_length (11 bits each), zero pad
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int SW = $clog2(ALPHABET_SIZE);
	localparam int TD = MAX_NODES * ALPHABET_SIZE;
	localparam int AW = $clog2(TD);
	localparam int FW = sab_pkg::FW;

	typedef enum logic [4:0] {
		S_INIT, S_CLR, S_IDLE, S_ARD, S_ACK, S_W1RD, S_W1CK, S_QRD, S_QCK,
		S_CLN2, S_CLN3, S_CPRD, S_CPWR, S_W2RD, S_W2CK, S_RRD, S_RCK
	} state_t;

	state_t state_q;

	logic [NW-1:0] cnt_q, last_q, p_q, np_q, q_q, nq_q, clr_node_q, idx_q;
	logic [NW-1:0] nplen_q, plen_q, qlen_q;
	logic [SW-1:0] c_q, k_q;
	logic          clr_walk_q, clr_resp_q, sym_ok_q;

	logic              res_v_q;
	sab_pkg::status_t  res_status_q;
	logic [NW-1:0]     res_target_q, res_link_q, res_len_q;

	logic [NW-1:0]    t_node, n_addr, t_wd;
	logic [SW-1:0]    t_sym;
	logic             t_we, n_we;
	logic [2*NW-1:0]  n_wd, n_rd;
	logic [NW-1:0]    t_rd;
	logic [AW-1:0]    t_addr;
	logic [NW-1:0]    rd_link, rd_len, cnt_inc;

	logic [4:0]  in_sym;
	logic [10:0] in_idx;
	logic        accept;

	assign in_sym  = s_tdata[4:0];
	assign in_idx  = s_tdata[15:5];
	assign accept  = s_tvalid && s_tready;
	assign rd_link = n_rd[2*NW-1:NW];
	assign rd_len  = n_rd[NW-1:0];
	assign cnt_inc = cnt_q + NW'(1);

	// shared address unit
	assign t_addr = AW'(t_node) * AW'(ALPHABET_SIZE) + AW'(t_sym);

	sab_spram #(.DEPTH(TD), .WIDTH(NW)) u_tmem (
		.clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd)
	);

	sab_spram #(.DEPTH(MAX_NODES), .WIDTH(2*NW)) u_nmem (
		.clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd)
	);

	always_comb begin
		t_node = '0;
		t_sym  = '0;
		t_we   = 1'b0;
		t_wd   = '0;
		n_addr = '0;
		n_we   = 1'b0;
		n_wd   = '0;
		case (state_q)
			S_INIT: begin
				n_addr = NW'(1);
				n_we   = 1'b1;
			end
			S_CLR: begin
				t_node = clr_node_q;
				t_sym  = k_q;
				t_we   = 1'b1;
			end
			S_ARD: begin
				n_addr = last_q;
			end
			S_ACK: begin
				n_addr = cnt_inc;
				n_we   = 1'b1;
				n_wd   = {NW'(0), rd_len + NW'(1)};
			end
			S_W1RD, S_W2RD: begin
				t_node = p_q;
				t_sym  = c_q;
				n_addr = p_q;
			end
			S_W1CK: begin
				t_node = p_q;
				t_sym  = c_q;
				if (t_rd == '0) begin
					t_we = 1'b1;
					t_wd = np_q;
					if (rd_link == '0) begin
						n_addr = np_q;
						n_we   = 1'b1;
						n_wd   = {NW'(1), nplen_q};
					end
				end
			end
			S_QRD: begin
				n_addr = q_q;
			end
			S_QCK: begin
				n_we = 1'b1;
				if (plen_q + NW'(1) == rd_len) begin
					n_addr = np_q;
					n_wd   = {q_q, nplen_q};
				end else begin
					n_addr = cnt_inc;
					n_wd   = {rd_link, plen_q + NW'(1)};
				end
			end
			S_CLN2: begin
				n_addr = q_q;
				n_we   = 1'b1;
				n_wd   = {nq_q, qlen_q};
			end
			S_CLN3: begin
				n_addr = np_q;
				n_we   = 1'b1;
				n_wd   = {nq_q, nplen_q};
			end
			S_CPRD: begin
				t_node = q_q;
				t_sym  = k_q;
			end
			S_CPWR: begin
				t_node = nq_q;
				t_sym  = k_q;
				t_we   = 1'b1;
				t_wd   = t_rd;
			end
			S_W2CK: begin
				t_node = p_q;
				t_sym  = c_q;
				if (t_rd == q_q) begin
					t_we = 1'b1;
					t_wd = nq_q;
				end
			end
			S_RRD: begin
				t_node = idx_q;
				t_sym  = c_q;
				n_addr = idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cnt_q        <= NW'(1);
			last_q       <= NW'(1);
			clr_walk_q   <= 1'b0;
			clr_resp_q   <= 1'b0;
			res_v_q      <= 1'b0;
			res_status_q <= sab_pkg::ST_OK;
			k_q          <= '0;
		end else begin
			if (res_v_q && m_tready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					cnt_q      <= NW'(1);
					last_q     <= NW'(1);
					clr_node_q <= NW'(1);
					clr_walk_q <= 1'b0;
					k_q        <= '0;
					state_q    <= S_CLR;
				end
				S_CLR: begin
					if (k_q == SW'(ALPHABET_SIZE - 1)) begin
						k_q <= '0;
						if (clr_walk_q) begin
							state_q <= S_W1RD;
						end else begin
							state_q <= S_IDLE;
							if (clr_resp_q) begin
								res_v_q      <= 1'b1;
								res_status_q <= sab_pkg::ST_OK;
								res_target_q <= '0;
								res_link_q   <= '0;
								res_len_q    <= '0;
							end
						end
					end else begin
						k_q <= k_q + SW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_target_q <= '0;
						res_link_q   <= '0;
						res_len_q    <= '0;
						case (sab_pkg::cmd_t'(s_tuser))
							sab_pkg::CMD_APPEND: begin
								if (32'(cnt_q) + 32'd2 > 32'(MAX_NODES - 1)) begin
									res_v_q      <= 1'b1;
									res_status_q <= sab_pkg::ST_FULL;
								end else if (32'(in_sym) >= 32'(ALPHABET_SIZE)) begin
									res_v_q      <= 1'b1;
									res_status_q <= sab_pkg::ST_OK;
								end else begin
									c_q     <= SW'(in_sym);
									p_q     <= last_q;
									state_q <= S_ARD;
								end
							end
							sab_pkg::CMD_READ: begin
								if (in_idx == '0 || 32'(in_idx) > 32'(cnt_q) ||
								    32'(in_idx) >= 32'(MAX_NODES)) begin
									res_v_q      <= 1'b1;
									res_status_q <= sab_pkg::ST_NOREAD;
								end else begin
									idx_q    <= NW'(in_idx);
									c_q      <= SW'(in_sym);
									sym_ok_q <= 32'(in_sym) < 32'(ALPHABET_SIZE);
									state_q  <= S_RRD;
								end
							end
							sab_pkg::CMD_RESTART: begin
								clr_resp_q <= 1'b1;
								state_q    <= S_INIT;
							end
							default: begin
								res_v_q      <= 1'b1;
								res_status_q <= sab_pkg::ST_OK;
							end
						endcase
					end
				end
				S_ARD: begin
					state_q <= S_ACK;
				end
				S_ACK: begin
					np_q       <= cnt_inc;
					cnt_q      <= cnt_inc;
					nplen_q    <= rd_len + NW'(1);
					clr_node_q <= cnt_inc;
					clr_walk_q <= 1'b1;
					clr_resp_q <= 1'b0;
					k_q        <= '0;
					state_q    <= S_CLR;
				end
				S_W1RD: begin
					state_q <= S_W1CK;
				end
				S_W1CK: begin
					if (t_rd == '0) begin
						p_q <= rd_link;
						if (rd_link == '0) begin
							last_q       <= np_q;
							res_v_q      <= 1'b1;
							res_status_q <= sab_pkg::ST_OK;
							res_target_q <= '0;
							res_link_q   <= '0;
							res_len_q    <= '0;
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_W1RD;
						end
					end else begin
						q_q     <= t_rd;
						plen_q  <= rd_len;
						state_q <= S_QRD;
					end
				end
				S_QRD: begin
					state_q <= S_QCK;
				end
				S_QCK: begin
					if (plen_q + NW'(1) == rd_len) begin
						last_q       <= np_q;
						res_v_q      <= 1'b1;
						res_status_q <= sab_pkg::ST_OK;
						res_target_q <= '0;
						res_link_q   <= '0;
						res_len_q    <= '0;
						state_q      <= S_IDLE;
					end else begin
						nq_q    <= cnt_inc;
						cnt_q   <= cnt_inc;
						qlen_q  <= rd_len;
						state_q <= S_CLN2;
					end
				end
				S_CLN2: begin
					state_q <= S_CLN3;
				end
				S_CLN3: begin
					k_q     <= '0;
					state_q <= S_CPRD;
				end
				S_CPRD: begin
					state_q <= S_CPWR;
				end
				S_CPWR: begin
					if (k_q == SW'(ALPHABET_SIZE - 1)) begin
						k_q     <= '0;
						state_q <= S_W2RD;
					end else begin
						k_q     <= k_q + SW'(1);
						state_q <= S_CPRD;
					end
				end
				S_W2RD: begin
					state_q <= S_W2CK;
				end
				S_W2CK: begin
					if (t_rd == q_q && rd_link != '0) begin
						p_q     <= rd_link;
						state_q <= S_W2RD;
					end else begin
						last_q       <= np_q;
						res_v_q      <= 1'b1;
						res_status_q <= sab_pkg::ST_OK;
						res_target_q <= '0;
						res_link_q   <= '0;
						res_len_q    <= '0;
						state_q      <= S_IDLE;
					end
				end
				S_RRD: begin
					state_q <= S_RCK;
				end
				S_RCK: begin
					res_v_q      <= 1'b1;
					res_status_q <= sab_pkg::ST_OK;
					res_target_q <= sym_ok_q ? t_rd : '0;
					res_link_q   <= rd_link;
					res_len_q    <= rd_len;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE) && !res_v_q;
	assign m_tvalid = res_v_q;
	assign m_tuser  = res_status_q;
	assign m_tdata  = {1'b0, FW'(res_len_q), FW'(res_link_q), FW'(res_target_q),
	                   FW'(cnt_q), FW'(last_q)};

	`SAB_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, 32'(cnt_q) <= 32'(MAX_NODES - 1))
	`SAB_ASSERT_NOW(a_last_created, clk, arst_n, state_q == S_IDLE,
		last_q != '0 && last_q <= cnt_q)
	`SAB_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !s_tready)

endmodule

>>> rtl/sab_spram.sv
// ----------------------------------------------------------------------------
// sab_spram
// Single-port RAM, one read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module sab_spram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 22
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> verif/suffix_automaton_builder_tb.sv
// ----------------------------------------------------------------------------
// suffix_automaton_builder_tb
// Drives append, read, restart and no-op transactions through the stream
// ports with random gaps and stalls. Each result is checked against an
// in-bench model of the node table, and a few directed rows against fixed values.
// ----------------------------------------------------------------------------
module suffix_automaton_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 2048;
	localparam int ALPHA = 26;
	localparam int NDIR = 22;

	typedef struct packed {
		sab_pkg::status_t status;
		logic [10:0] last_node;
		logic [10:0] node_count;
		logic [10:0] target_node;
		logic [10:0] link_node;
		logic [10:0] longest_length;
	} sam_result_t;

	typedef struct {
		sab_pkg::cmd_t cmd;
		logic [4:0]  sym;
		logic [10:0] idx;
		bit          fixed;
		sam_result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;

	suffix_automaton_builder dut (.*);

	always #10 clk = ~clk;

	// model of the automaton
	logic [10:0] trans[NODES][ALPHA];
	logic [10:0] slink[NODES];
	logic [10:0] nlen[NODES];
	int unsigned last_ptr, node_cnt;

	sam_result_t pending_results[$];
	int errors = 0;
	bit stim_done = 1'b0;

	function automatic int unsigned alloc_node(int unsigned len);
		node_cnt++;
		for (int i = 0; i < ALPHA; i++)
			trans[node_cnt][i] = '0;
		slink[node_cnt] = '0;
		nlen[node_cnt] = 11'(len);
		return node_cnt;
	endfunction

	function automatic void extend_text(int unsigned c);
		int unsigned p, np, q, nq;
		p = last_ptr;
		np = alloc_node(32'(nlen[p]) + 1);
		while (p != 0 && trans[p][c] == '0) begin
			trans[p][c] = 11'(np);
			p = 32'(slink[p]);
		end
		if (p == 0) begin
			slink[np] = 11'd1;
		end else begin
			q = 32'(trans[p][c]);
			if (32'(nlen[p]) + 1 == 32'(nlen[q])) begin
				slink[np] = 11'(q);
			end else begin
				nq = alloc_node(32'(nlen[p]) + 1);
				for (int i = 0; i < ALPHA; i++)
					trans[nq][i] = trans[q][i];
				slink[nq] = slink[q];
				slink[q] = 11'(nq);
				slink[np] = 11'(nq);
				while (p != 0 && trans[p][c] == 11'(q)) begin
					trans[p][c] = 11'(nq);
					p = 32'(slink[p]);
				end
			end
		end
		last_ptr = np;
	endfunction

	function automatic void reset_to_root();
		node_cnt = 0;
		void'(alloc_node(0));
		last_ptr = 1;
	endfunction

	function automatic sam_result_t apply_transaction(sab_pkg::cmd_t cmd, int unsigned sym,
			int unsigned idx);
		sam_result_t r;
		r = '0;
		r.status = sab_pkg::ST_OK;
		case (cmd)
			sab_pkg::CMD_APPEND: begin
				if (node_cnt + 2 > NODES - 1)
					r.status = sab_pkg::ST_FULL;
				else if (sym < ALPHA)
					extend_text(sym);
			end
			sab_pkg::CMD_READ: begin
				if (idx == 0 || idx > node_cnt) begin
					r.status = sab_pkg::ST_NOREAD;
				end else begin
					if (sym < ALPHA)
						r.target_node = trans[idx][sym];
					r.link_node = slink[idx];
					r.longest_length = nlen[idx];
				end
			end
			sab_pkg::CMD_RESTART: reset_to_root();
			default: ;
		endcase
		r.last_node = 11'(last_ptr);
		r.node_count = 11'(node_cnt);
		return r;
	endfunction

	function automatic sam_result_t fixed_res(sab_pkg::status_t st, int unsigned ln,
			int unsigned nc, int unsigned tn, int unsigned lk, int unsigned ll);
		sam_result_t r;
		r.status = st;
		r.last_node = 11'(ln);
		r.node_count = 11'(nc);
		r.target_node = 11'(tn);
		r.link_node = 11'(lk);
		r.longest_length = 11'(ll);
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	// with s_tvalid still high
	task automatic send(sab_pkg::cmd_t cmd, logic [4:0] sym, logic [10:0] idx, bit fixed,
			sam_result_t fres);
		sam_result_t r;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {idx, sym};
		do
			@(posedge clk);
		while (!s_tready);
		r = apply_transaction(cmd, 32'(sym), 32'(idx));
		if (fixed && r !== fres) begin
			errors++;
			if (errors <= 10)
				$display("directed row mismatch: table %h model %h", fres, r);
		end
		pending_results = {pending_results, (fixed ? fres : r)};
		@(negedge clk);
	endtask

	task automatic send_gapped(sab_pkg::cmd_t cmd, logic [4:0] sym, logic [10:0] idx);
		// bursts: mostly back to back, sometimes a gap
		if ($urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		send(cmd, sym, idx, 1'b0, '0);
	endtask

	// receiver stall pattern
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(5, 40)) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		sam_result_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = sab_pkg::status_t'(m_tuser);
			got.last_node = m_tdata[10:0];
			got.node_count = m_tdata[21:11];
			got.target_node = m_tdata[32:22];
			got.link_node = m_tdata[43:33];
			got.longest_length = m_tdata[54:44];
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transaction %h", got);
			end else begin
				exp_r = pending_results.pop_front();
				if (got !== exp_r || m_tdata[55] !== 1'b0) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: exp st=%0d last=%0d cnt=%0d tgt=%0d ",
							"lnk=%0d len=%0d | got st=%0d last=%0d cnt=%0d ",
							"tgt=%0d lnk=%0d len=%0d"},
							exp_r.status, exp_r.last_node, exp_r.node_count,
							exp_r.target_node, exp_r.link_node, exp_r.longest_length,
							got.status, got.last_node, got.node_count,
							got.target_node, got.link_node, got.longest_length);
				end
			end
		end
	end

	stim_row_t dir_rows[NDIR];

	initial begin
		int n, kind, len;
		// "abcbc" style text builds clones; fixed rows after reset/restart and errors
		dir_rows = '{
			'{sab_pkg::CMD_READ, 5'd0, 11'd1, 1'b1,
				fixed_res(sab_pkg::ST_OK, 1, 1, 0, 0, 0)},
			'{sab_pkg::CMD_READ, 5'd0, 11'd0, 1'b1,
				fixed_res(sab_pkg::ST_NOREAD, 1, 1, 0, 0, 0)},
			'{sab_pkg::CMD_READ, 5'd31, 11'd2047, 1'b1,
				fixed_res(sab_pkg::ST_NOREAD, 1, 1, 0, 0, 0)},
			'{sab_pkg::CMD_NOP, 5'd31, 11'd2047, 1'b1,
				fixed_res(sab_pkg::ST_OK, 1, 1, 0, 0, 0)},
			'{sab_pkg::CMD_APPEND, 5'd0, 11'd0, 1'b1,
				fixed_res(sab_pkg::ST_OK, 2, 2, 0, 0, 0)},
			'{sab_pkg::CMD_APPEND,  5'd1,  11'd0,    1'b0, '0},
			'{sab_pkg::CMD_APPEND,  5'd25, 11'd0,    1'b0, '0},
			'{sab_pkg::CMD_APPEND,  5'd1,  11'd0,    1'b0, '0},
			'{sab_pkg::CMD_APPEND,  5'd25, 11'd0,    1'b0, '0},
			'{sab_pkg::CMD_APPEND,  5'd26, 11'd0,    1'b0, '0},
			'{sab_pkg::CMD_APPEND,  5'd31, 11'd0,    1'b0, '0},
			'{sab_pkg::CMD_APPEND,  5'd0,  11'd0,    1'b0, '0},
			'{sab_pkg::CMD_APPEND,  5'd0,  11'd0,    1'b0, '0},
			'{sab_pkg::CMD_READ,    5'd1,  11'd1,    1'b0, '0},
			'{sab_pkg::CMD_READ,    5'd25, 11'd3,    1'b0, '0},
			'{sab_pkg::CMD_READ,    5'd0,  11'd6,    1'b0, '0},
			'{sab_pkg::CMD_READ,    5'd0,  11'd7,    1'b0, '0},
			'{sab_pkg::CMD_READ,    5'd30, 11'd2,    1'b0, '0},
			'{sab_pkg::CMD_READ,    5'd0,  11'd1000, 1'b0, '0},
			'{sab_pkg::CMD_RESTART, 5'd0, 11'd0, 1'b1,
				fixed_res(sab_pkg::ST_OK, 1, 1, 0, 0, 0)},
			'{sab_pkg::CMD_READ, 5'd0, 11'd2, 1'b1,
				fixed_res(sab_pkg::ST_NOREAD, 1, 1, 0, 0, 0)},
			'{sab_pkg::CMD_READ, 5'd3, 11'd1, 1'b1,
				fixed_res(sab_pkg::ST_OK, 1, 1, 0, 0, 0)}
		};
		for (int i = 0; i < NODES; i++) begin
			slink[i] = '0;
			nlen[i] = '0;
		end
		reset_to_root();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].idx, dir_rows[i].fixed,
				dir_rows[i].res);

		// hold off until every result is back
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		@(negedge clk);

		n = 0;
		while (n < 500) begin
			kind = $urandom_range(0, 19);
			if (kind < 12) begin
				// text run over a small alphabet, then probing reads
				len = $urandom_range(3, 16);
				for (int k = 0; k < len; k++)
					send_gapped(sab_pkg::CMD_APPEND,
						5'($urandom_range(0, $urandom_range(1, 25))), '0);
				for (int k = 0; k < 4; k++)
					send_gapped(sab_pkg::CMD_READ, 5'($urandom_range(0, 25)),
						11'($urandom_range(1, node_cnt)));
				n += len + 4;
			end else if (kind < 15) begin
				send_gapped(sab_pkg::CMD_READ, 5'($urandom_range(0, 31)),
					11'($urandom_range(0, 2047)));
				n++;
			end else if (kind < 17) begin
				send_gapped(sab_pkg::CMD_APPEND, 5'($urandom_range(0, 31)),
					11'($urandom_range(0, 2047)));
				n++;
			end else if (kind < 19) begin
				send_gapped(sab_pkg::CMD_RESTART, 5'($urandom_range(0, 31)),
					11'($urandom_range(0, 2047)));
				n++;
			end else begin
				send_gapped(sab_pkg::CMD_NOP, 5'($urandom_range(0, 31)),
					11'($urandom_range(0, 2047)));
				n++;
			end
		end

		// reads around the top node
		send(sab_pkg::CMD_READ, 5'd1, 11'(node_cnt), 1'b0, '0);
		send(sab_pkg::CMD_READ, 5'd0, 11'(node_cnt + 1), 1'b0, '0);
		send(sab_pkg::CMD_READ, 5'd0, 11'd2047, 1'b0, '0);
		send(sab_pkg::CMD_RESTART, '0, '0, 1'b0, '0);
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done && pending_results.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#200ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
